@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/mfq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mfq_pkg;

	localparam int TASKS   = 64;
	localparam int LEVELS  = 4;
	localparam int TASK_W  = 6;
	localparam int LEVEL_W = 2;
	localparam int MODE_W  = 3;
	localparam int READY_W = 4;
	localparam int CNT_W   = 7;

	typedef logic [TASK_W-1:0]  task_id_t;
	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [CNT_W-1:0]   count_t;
	typedef logic [LEVELS-1:0]  bitmap_t;

	localparam count_t COUNT_MAX = '1;

	typedef enum logic [MODE_W-1:0] {
		MODE_ENQ  = 3'd0,
		MODE_DEQ  = 3'd1,
		MODE_PICK = 3'd2,
		MODE_PUT  = 3'd3,
		MODE_RUN  = 3'd4
	} mfq_mode_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} mfq_state_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		task_id_t          task_id;
		level_t            level;
	} mfq_req_t;

	typedef struct packed {
		logic               pick_valid;
		task_id_t           picked_task;
		logic [READY_W-1:0] ready_bits;
		logic               queue_ready;
	} mfq_rsp_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;
		logic commit;
	} mfq_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic out_free;
	} mfq_sts_t;

	function automatic count_t sat_inc(count_t v);
		return (v == COUNT_MAX) ? v : v + count_t'(1);
	endfunction

	function automatic count_t sat_dec(count_t v);
		return (v == '0) ? v : v - count_t'(1);
	endfunction

endpackage
`default_nettype wire

@@ rtl/mfq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mfq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire mfq_pkg::mfq_sts_t sts,
	output mfq_pkg::mfq_cmd_t      cmd
);
	import mfq_pkg::*;

	mfq_state_t state_q;
	mfq_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall   = 1'b1;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_stall   = 1'b0;
				cmd.capture = req_valid;
			end
			ST_EXEC: begin
				// hold until the result register can take the beat
				cmd.commit = sts.out_free;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/mfq_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mfq_dpath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mfq_pkg::mfq_req_t req,
	input  wire mfq_pkg::mfq_cmd_t cmd,
	output mfq_pkg::mfq_sts_t      sts,
	input  wire logic              rsp_stall,
	output logic                   rsp_valid,
	output mfq_pkg::mfq_rsp_t      rsp
);
	import mfq_pkg::*;

	// Link memories and per-task level, read at one address, written at one.
	task_id_t next_mem [TASKS];
	task_id_t prev_mem [TASKS];
	level_t   lvl_mem  [TASKS];

	task_id_t rd_next_q;
	task_id_t rd_prev_q;
	level_t   rd_lvl_q;
	task_id_t rd_addr;

	mfq_req_t item_q;

	logic [TASKS-1:0] listed_q, listed_d;
	task_id_t head_q [LEVELS];
	task_id_t head_d [LEVELS];
	task_id_t tail_q [LEVELS];
	task_id_t tail_d [LEVELS];
	count_t   lcnt_q [LEVELS];
	count_t   lcnt_d [LEVELS];
	count_t   cnt_q  [LEVELS];
	count_t   cnt_d  [LEVELS];
	count_t   total_q, total_d;
	bitmap_t  bitmap_q, bitmap_d;
	logic     qflag_q, qflag_d;

	logic      rsp_valid_q;
	mfq_rsp_t  rsp_q, rsp_d;

	logic      nx_we, pv_we, lv_we;
	task_id_t  nx_wa, nx_wd, pv_wa, pv_wd;

	task_id_t  t;
	level_t    lv;
	level_t    ul;
	logic      listed;
	logic      usable;
	mfq_mode_t mode_e;
	logic      found;
	level_t    sel;
	logic      pick_v;
	task_id_t  pick_t;

	assign rd_addr = cmd.capture ? req.task_id : item_q.task_id;

	assign t      = item_q.task_id;
	assign lv     = item_q.level;
	assign ul     = rd_lvl_q;
	assign listed = listed_q[t];
	assign usable = (int'(t) < TASKS) && (int'(lv) < LEVELS);
	assign mode_e = mfq_mode_t'(item_q.mode);

	always_comb begin
		found = 1'b0;
		sel   = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (!found && bitmap_q[i]) begin
				found = 1'b1;
				sel   = level_t'(i);
			end
		end
	end

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		lcnt_d   = lcnt_q;
		cnt_d    = cnt_q;
		total_d  = total_q;
		bitmap_d = bitmap_q;
		qflag_d  = qflag_q;
		listed_d = listed_q;
		nx_we    = 1'b0;
		nx_wa    = t;
		nx_wd    = t;
		pv_we    = 1'b0;
		pv_wa    = t;
		pv_wd    = t;
		lv_we    = 1'b0;
		pick_v   = 1'b0;
		pick_t   = '0;
		case (mode_e)
			MODE_PICK: begin
				if (found && lcnt_q[sel] != '0) begin
					pick_v = 1'b1;
					pick_t = head_q[sel];
				end
			end
			MODE_ENQ, MODE_PUT: begin
				if (usable) begin
					if (!listed) begin
						// append at the tail
						if (lcnt_q[lv] == '0) begin
							head_d[lv] = t;
						end else begin
							nx_we = 1'b1;
							nx_wa = tail_q[lv];
							nx_wd = t;
							pv_we = 1'b1;
							pv_wa = t;
							pv_wd = tail_q[lv];
						end
						tail_d[lv]  = t;
						lcnt_d[lv]  = lcnt_q[lv] + count_t'(1);
						listed_d[t] = 1'b1;
						lv_we       = 1'b1;
					end
					bitmap_d[lv] = 1'b1;
					qflag_d      = 1'b1;
					if (mode_e == MODE_ENQ) begin
						cnt_d[lv] = sat_inc(cnt_q[lv]);
						total_d   = sat_inc(total_q);
					end
				end
			end
			MODE_DEQ, MODE_RUN: begin
				if (usable) begin
					if (listed) begin
						// drop from the level the task sits in
						if (lcnt_q[ul] > count_t'(1)) begin
							if (head_q[ul] == t) begin
								head_d[ul] = rd_next_q;
							end else if (tail_q[ul] == t) begin
								tail_d[ul] = rd_prev_q;
							end else begin
								nx_we = 1'b1;
								nx_wa = rd_prev_q;
								nx_wd = rd_next_q;
								pv_we = 1'b1;
								pv_wa = rd_next_q;
								pv_wd = rd_prev_q;
							end
						end
						lcnt_d[ul]  = lcnt_q[ul] - count_t'(1);
						listed_d[t] = 1'b0;
					end
					if (mode_e == MODE_DEQ) begin
						cnt_d[lv] = sat_dec(cnt_q[lv]);
						total_d   = sat_dec(total_q);
						if (cnt_d[lv] == '0) begin
							bitmap_d[lv] = 1'b0;
						end
						if (total_d == '0) begin
							qflag_d = 1'b0;
						end
					end else begin
						if (cnt_q[lv] == count_t'(1)) begin
							bitmap_d[lv] = 1'b0;
						end
						if (total_q == count_t'(1)) begin
							qflag_d = 1'b0;
						end
					end
				end
			end
			default: ;
		endcase
		rsp_d.pick_valid  = pick_v;
		rsp_d.picked_task = pick_t;
		rsp_d.ready_bits  = READY_W'(bitmap_d);
		rsp_d.queue_ready = qflag_d;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && nx_we) begin
			next_mem[nx_wa] <= nx_wd;
		end
		if (cmd.commit && pv_we) begin
			prev_mem[pv_wa] <= pv_wd;
		end
		if (cmd.commit && lv_we) begin
			lvl_mem[t] <= lv;
		end
		rd_next_q <= next_mem[rd_addr];
		rd_prev_q <= prev_mem[rd_addr];
		rd_lvl_q  <= lvl_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= req;
		end
		if (cmd.commit) begin
			head_q <= head_d;
			tail_q <= tail_d;
			rsp_q  <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listed_q <= '0;
			lcnt_q   <= '{default: '0};
			cnt_q    <= '{default: '0};
			total_q  <= '0;
			bitmap_q <= '0;
			qflag_q  <= 1'b0;
		end else if (cmd.commit) begin
			listed_q <= listed_d;
			lcnt_q   <= lcnt_d;
			cnt_q    <= cnt_d;
			total_q  <= total_d;
			bitmap_q <= bitmap_d;
			qflag_q  <= qflag_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign sts.out_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid    = rsp_valid_q;
	assign rsp          = rsp_q;

endmodule
`default_nettype wire

@@ rtl/multilevel_fifo_ready_queue_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Multilevel FIFO ready queue: 64 task ids spread over 4 priority levels (0 highest), each
// level a FIFO kept as a doubly linked list in two 64-entry link memories. Each request beat
// (enqueue, dequeue, pick, put back, set running) yields exactly one response beat carrying
// the pick result plus the ready bitmap and queue-ready flag after the operation. In the
// idle state a request is accepted and the task's link and level entries are read from the
// memories; in the execute state heads, tails, counts and links are updated and the
// response register is loaded. No new request is accepted until that update is done, and
// the update waits only while a finished response is held by a stalled consumer.
// Link memories need no clearing after reset; out-of-range ids, levels or modes produce a
// response with the current status and change nothing.
module multilevel_fifo_ready_queue_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire mfq_pkg::mfq_req_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output mfq_pkg::mfq_rsp_t      rsp
);
	import mfq_pkg::*;

	mfq_cmd_t cmd;
	mfq_sts_t sts;

	// Sequence each request beat: capture and read, then commit.
	mfq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hold the lists, counts, bitmap and the response register.
	mfq_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

@@ rtl/mfq_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mfq_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_stall,
	input wire logic              rsp_valid,
	input wire logic              rsp_stall,
	input wire mfq_pkg::mfq_rsp_t rsp
);
	// one request in flight: stall right after an accepted beat
`ASSERT_NEXT(a_stall_after_accept, clk, arst_n, req_valid && !req_stall, req_stall)

	// a fresh response follows an accepted request beat
`ASSERT_IMP(a_rsp_from_req, clk, arst_n, $rose(rsp_valid), $past(req_valid && !req_stall, 2))

	// a stalled response beat holds
`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// a valid pick needs a ready level; a failed pick reports task zero
`ASSERT_IMP(a_pick_ready, clk, arst_n, rsp_valid && rsp.pick_valid, rsp.ready_bits != '0)
`ASSERT_IMP(a_nopick_zero, clk, arst_n, rsp_valid && !rsp.pick_valid, rsp.picked_task == '0)

endmodule

bind multilevel_fifo_ready_queue_top mfq_checker u_mfq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
`default_nettype wire

@@ bench/multilevel_fifo_ready_queue_top_tb.sv @@
`timescale 1ns / 1ps
module multilevel_fifo_ready_queue_top_tb;
	import mfq_pkg::*;

	// Overall run limit and settle time after the last response.
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE_TICKS = 12;
	localparam int LONG_HOLD    = 150;
	localparam int HOLD_AFTER   = 60;

	// Mode encodings the block must ignore.
	localparam logic [MODE_W-1:0] MODE_UNUSED_5 = 3'd5;
	localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

	typedef enum int {
		PLAN_OFF,
		PLAN_WAITING,
		PLAN_RUNNING
	} plan_t;

	// One request beat waiting to be offered: the payload, the idle cycles to insert
	// after it, and whether to hold it back until every response has come home.
	typedef struct {
		mfq_req_t    op;
		int unsigned gap;
		bit          drain;
	} queued_op_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	mfq_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	mfq_rsp_t rsp;

	multilevel_fifo_ready_queue_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow of the run queue. Counts track tasks logically on the queue,
	// the lists track tasks actually waiting, so a running task is counted
	// but not linked.
	// ------------------------------------------------------------------
	task_id_t succ_of [TASKS];
	task_id_t pred_of [TASKS];
	bit       on_list [TASKS] = '{default: 1'b0};
	level_t   home_lvl[TASKS];
	task_id_t lvl_head[LEVELS];
	task_id_t lvl_tail[LEVELS];
	count_t   lvl_cnt [LEVELS] = '{default: '0};
	int       lvl_len [LEVELS] = '{default: 0};
	count_t   tot_cnt = '0;
	bitmap_t  rdy_map = '0;
	logic     q_ready = 1'b0;

	// Append at the tail of a level; a task already linked keeps its place.
	function automatic void append_task(task_id_t t, level_t lv);
		if (on_list[t])
			return;
		if (lvl_len[lv] == 0) begin
			lvl_head[lv] = t;
			pred_of[t] = t;
		end else begin
			succ_of[lvl_tail[lv]] = t;
			pred_of[t] = lvl_tail[lv];
		end
		succ_of[t] = t;
		lvl_tail[lv] = t;
		lvl_len[lv]++;
		on_list[t] = 1'b1;
		home_lvl[t] = lv;
	endfunction

	// Unlink from whatever level the task sits in, which need not be the level of the
	// request. An unlinked task is left alone. Removing the head does not touch the new
	// head's back link.
	function automatic void remove_task(task_id_t t);
		level_t   lv;
		task_id_t p;
		task_id_t n;
		if (!on_list[t])
			return;
		lv = home_lvl[t];
		p = pred_of[t];
		n = succ_of[t];
		if (lvl_len[lv] > 1) begin
			if (lvl_head[lv] == t) begin
				lvl_head[lv] = n;
			end else if (lvl_tail[lv] == t) begin
				lvl_tail[lv] = p;
				succ_of[p] = p;
			end else begin
				succ_of[p] = n;
				pred_of[n] = p;
			end
		end
		lvl_len[lv]--;
		on_list[t] = 1'b0;
	endfunction

	// Advance the shadow by one request and return the response it must produce.
	function automatic mfq_rsp_t run_queue_step(mfq_req_t r);
		mfq_rsp_t o;
		bitmap_t  lvl_bit;
		int       i;
		bit       usable;
		o = '0;
		lvl_bit = bitmap_t'(1) << r.level;
		usable = (int'(r.task_id) < TASKS) && (int'(r.level) < LEVELS);
		if (r.mode == MODE_PICK) begin
			// Lowest set ready bit wins; a set bit over an empty list finds nothing.
			i = 0;
			while (i < LEVELS && !rdy_map[i])
				i++;
			if (i < LEVELS && lvl_len[i] != 0) begin
				o.pick_valid = 1'b1;
				o.picked_task = lvl_head[i];
			end
		end else if (usable) begin
			case (r.mode)
				MODE_ENQ: begin
					append_task(r.task_id, r.level);
					if (lvl_cnt[r.level] != COUNT_MAX)
						lvl_cnt[r.level]++;
					if (tot_cnt != COUNT_MAX)
						tot_cnt++;
					rdy_map |= lvl_bit;
					q_ready = 1'b1;
				end
				MODE_DEQ: begin
					remove_task(r.task_id);
					if (lvl_cnt[r.level] != '0)
						lvl_cnt[r.level]--;
					if (tot_cnt != '0)
						tot_cnt--;
					if (lvl_cnt[r.level] == '0)
						rdy_map &= ~lvl_bit;
					if (tot_cnt == '0)
						q_ready = 1'b0;
				end
				MODE_PUT: begin
					append_task(r.task_id, r.level);
					rdy_map |= lvl_bit;
					q_ready = 1'b1;
				end
				MODE_RUN: begin
					remove_task(r.task_id);
					if (lvl_cnt[r.level] == count_t'(1))
						rdy_map &= ~lvl_bit;
					if (tot_cnt == count_t'(1))
						q_ready = 1'b0;
				end
				default: begin
					// undefined modes leave everything as it is
				end
			endcase
		end
		o.ready_bits = rdy_map[READY_W-1:0];
		o.queue_ready = q_ready;
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus planning
	// ------------------------------------------------------------------
	queued_op_t op_backlog[$];
	mfq_rsp_t   status_due[$];
	plan_t      plan_state[TASKS] = '{default: PLAN_OFF};
	level_t     plan_lvl  [TASKS] = '{default: '0};

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 93)
			return $urandom_range(4, 9);
		return $urandom_range(10, 30);
	endfunction

	function automatic void queue_op(logic [MODE_W-1:0] m, task_id_t t, level_t lv,
			bit calm, bit drain);
		queued_op_t q;
		q.op.mode = m;
		q.op.task_id = t;
		q.op.level = lv;
		q.gap = (calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
		q.drain = drain;
		op_backlog.push_back(q);
	endfunction

	function automatic int find_task(plan_t s);
		int base;
		int k;
		int t;
		base = $urandom_range(0, TASKS - 1);
		for (k = 0; k < TASKS; k++) begin
			t = (base + k) % TASKS;
			if (plan_state[t] == s)
				return t;
		end
		return -1;
	endfunction

	// Mostly well-formed scheduler traffic (enqueue, pick, run, put back, remove)
	// with a slice of noise: any mode, any id, any level.
	function automatic void plan_random_op(bit calm);
		int               r;
		int               t;
		logic [MODE_W-1:0] m;
		r = $urandom_range(0, 99);
		t = -1;
		m = MODE_ENQ;
		if (r >= 85) begin
			queue_op(MODE_W'($urandom_range(0, 7)), task_id_t'($urandom),
				level_t'($urandom), calm, 1'b0);
			return;
		end else if (r >= 30 && r < 45) begin
			queue_op(MODE_PICK, task_id_t'($urandom), level_t'($urandom), calm, 1'b0);
			return;
		end else if (r >= 45 && r < 58) begin
			m = MODE_RUN;
			t = find_task(PLAN_WAITING);
		end else if (r >= 58 && r < 70) begin
			m = MODE_PUT;
			t = find_task(PLAN_RUNNING);
		end else if (r >= 70) begin
			m = MODE_DEQ;
			t = find_task(PLAN_WAITING);
			if (t < 0)
				t = find_task(PLAN_RUNNING);
		end
		if (t < 0) begin
			m = MODE_ENQ;
			t = find_task(PLAN_OFF);
			if (t < 0)
				t = $urandom_range(0, TASKS - 1);
			plan_lvl[t] = level_t'($urandom);
		end
		queue_op(m, task_id_t'(t), plan_lvl[t], calm, 1'b0);
		case (m)
			MODE_RUN: plan_state[t] = PLAN_RUNNING;
			MODE_DEQ: plan_state[t] = PLAN_OFF;
			default:  plan_state[t] = PLAN_WAITING;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Request driver: offer the backlog one beat at a time, hold the payload
	// while stalled, and predict each beat at the edge it is taken.
	// ------------------------------------------------------------------
	int unsigned idle_left;
	int unsigned ops_sent;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			idle_left <= 0;
			ops_sent <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				status_due.push_back(run_queue_step(req));
				ops_sent <= ops_sent + 1;
			end
			if (!req_valid || !req_stall) begin
				if (idle_left != 0) begin
					idle_left <= idle_left - 1;
					req_valid <= 1'b0;
				end else if (op_backlog.size() != 0 &&
						(!op_backlog[0].drain || status_due.size() == 0)) begin
					req <= op_backlog[0].op;
					req_valid <= 1'b1;
					idle_left <= op_backlog[0].gap;
					op_backlog.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Response back-pressure. Random stalls, quiet windows with none, and a
	// single long hold once traffic is flowing so the block backs up and
	// stalls the request side.
	// ------------------------------------------------------------------
	int unsigned results_seen;
	int unsigned stall_left;
	int unsigned hold_left;
	bit          hold_done;
	int unsigned stall_ticks;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
			stall_ticks <= 0;
		end else begin
			stall_ticks <= stall_ticks + 1;
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done <= 1'b1;
				hold_left <= LONG_HOLD;
				rsp_stall <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				rsp_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
				// every third window of stall_ticks runs without new random stalls
				if ((stall_ticks / 400) % 3 != 2 && $urandom_range(0, 3) == 0)
					stall_left <= pick_gap();
			end
		end
	end

	// ------------------------------------------------------------------
	// Response checker: compare each taken beat with the oldest prediction.
	// ------------------------------------------------------------------
	mfq_rsp_t    due_now;
	int unsigned fail_cnt = 0;
	int unsigned picks_hit;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_seen <= 0;
			picks_hit <= 0;
		end else if (rsp_valid && !rsp_stall) begin
			results_seen <= results_seen + 1;
			if (status_due.size() == 0) begin
				$error("response beat with no request outstanding");
				fail_cnt++;
			end else begin
				due_now = status_due.pop_front();
				if (rsp.pick_valid !== due_now.pick_valid) begin
					$error("pick_valid: expected %0d, got %0d", due_now.pick_valid,
						rsp.pick_valid);
					fail_cnt++;
				end
				if (rsp.picked_task !== due_now.picked_task) begin
					$error("picked_task: expected %0d, got %0d", due_now.picked_task,
						rsp.picked_task);
					fail_cnt++;
				end
				if (rsp.ready_bits !== due_now.ready_bits) begin
					$error("ready_bits: expected %b, got %b", due_now.ready_bits,
						rsp.ready_bits);
					fail_cnt++;
				end
				if (rsp.queue_ready !== due_now.queue_ready) begin
					$error("queue_ready: expected %0d, got %0d", due_now.queue_ready,
						rsp.queue_ready);
					fail_cnt++;
				end
				if (due_now.pick_valid)
					picks_hit <= picks_hit + 1;
			end
		end
	end

	// Hard stop if the handshakes ever hang.
	int unsigned run_ticks = 0;

	always @(posedge clk) begin
		run_ticks <= run_ticks + 1;
		if (run_ticks == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence: directed corner cases, random traffic with a calm stretch,
	// a count-saturation burst, a short random tail.
	// ------------------------------------------------------------------
	initial begin
		int n;

		// Empty queue: pick finds nothing; removals of unlinked tasks pin counts at zero.
		queue_op(MODE_PICK, 6'd63, 2'd3, 1'b0, 1'b0);
		queue_op(MODE_DEQ, 6'd5, 2'd0, 1'b0, 1'b0);
		queue_op(MODE_RUN, 6'd7, 2'd2, 1'b0, 1'b0);
		// Extreme ids on the lowest level, then the same task again: it keeps its place.
		queue_op(MODE_ENQ, 6'd0, 2'd3, 1'b0, 1'b0);
		queue_op(MODE_ENQ, 6'd63, 2'd3, 1'b0, 1'b0);
		queue_op(MODE_ENQ, 6'd0, 2'd3, 1'b0, 1'b0);
		queue_op(MODE_PICK, 6'd0, 2'd0, 1'b0, 1'b0);
		// Top level wins the pick; running its only task clears its bit.
		queue_op(MODE_ENQ, 6'd10, 2'd0, 1'b0, 1'b0);
		queue_op(MODE_PICK, 6'd0, 2'd0, 1'b0, 1'b0);
		queue_op(MODE_RUN, 6'd10, 2'd0, 1'b0, 1'b0);
		queue_op(MODE_PICK, 6'd0, 2'd0, 1'b0, 1'b0);
		queue_op(MODE_PUT, 6'd10, 2'd0, 1'b0, 1'b0);
		queue_op(MODE_DEQ, 6'd10, 2'd0, 1'b0, 1'b0);
		// Two tasks on one level both running: bit stays set over an empty list.
		queue_op(MODE_ENQ, 6'd20, 2'd1, 1'b0, 1'b0);
		queue_op(MODE_ENQ, 6'd21, 2'd1, 1'b0, 1'b0);
		queue_op(MODE_RUN, 6'd20, 2'd1, 1'b0, 1'b0);
		queue_op(MODE_RUN, 6'd21, 2'd1, 1'b0, 1'b0);
		queue_op(MODE_PICK, 6'd0, 2'd0, 1'b0, 1'b0);
		// Remove with a level other than the one the task is linked in.
		queue_op(MODE_DEQ, 6'd63, 2'd1, 1'b0, 1'b0);
		// Undefined modes do nothing.
		queue_op(MODE_UNUSED_5, 6'd63, 2'd3, 1'b0, 1'b0);
		queue_op(MODE_UNUSED_6, 6'd0, 2'd0, 1'b0, 1'b0);
		queue_op(MODE_UNUSED_7, 6'd42, 2'd2, 1'b0, 1'b0);
		queue_op(MODE_DEQ, 6'd0, 2'd3, 1'b0, 1'b0);
		queue_op(MODE_PUT, 6'd21, 2'd2, 1'b0, 1'b0);
		queue_op(MODE_PICK, 6'd0, 2'd0, 1'b0, 1'b0);

		// Pause for the directed responses before random traffic starts.
		queue_op(MODE_PICK, 6'd0, 2'd0, 1'b0, 1'b1);
		for (n = 0; n < 130; n++)
			plan_random_op(n >= 60 && n < 90);

		// Drive one level's count and the total past saturation, then back past zero.
		queue_op(MODE_ENQ, task_id_t'($urandom), 2'd2, 1'b0, 1'b1);
		for (n = 0; n < 130; n++)
			queue_op(MODE_ENQ, task_id_t'($urandom), 2'd2, n < 40, 1'b0);
		for (n = 0; n < 3; n++)
			queue_op(MODE_PICK, task_id_t'($urandom), level_t'($urandom), 1'b0, 1'b0);
		for (n = 0; n < 133; n++)
			queue_op(MODE_DEQ, task_id_t'($urandom), 2'd2, 1'b0, 1'b0);

		plan_state = '{default: PLAN_OFF};
		for (n = 0; n < 30; n++)
			plan_random_op(1'b0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (op_backlog.size() != 0 || req_valid || status_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);

		$display("Run covered %0d request beats and %0d response beats, %0d picks found a task,",
			ops_sent, results_seen, picks_hit);
		$display("including undefined modes, count saturation and a long response hold; %0d mismatches.",
			fail_cnt);
		if (fail_cnt == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
